FILE: rtl/nmwf_pkg.sv
// nmwf_pkg: sizes, codes, cell handshake types and byte normalization functions
// for the normalized multi-word filter; no dependencies
package nmwf_pkg;

  localparam int NUM_WORDS = 16;
  localparam int MAX_WORD_BYTES = 32;
  localparam int LEN_W = $clog2(MAX_WORD_BYTES + 1);
  localparam int WU_W = 5;
  localparam int MODE_W = 2;
  localparam int STAT_W = 2;

  localparam logic [MODE_W-1:0] MODE_MSG = 2'd0;
  localparam logic [MODE_W-1:0] MODE_BAN = 2'd1;
  localparam logic [MODE_W-1:0] MODE_UNBAN = 2'd2;
  localparam logic [MODE_W-1:0] MODE_OTHER = 2'd3;

  localparam logic [STAT_W-1:0] ST_OK = 2'd0;
  localparam logic [STAT_W-1:0] ST_FULL = 2'd1;
  localparam logic [STAT_W-1:0] ST_LONG = 2'd2;
  localparam logic [STAT_W-1:0] ST_ABSENT = 2'd3;

  typedef logic [7:0] byte_t;
  typedef byte_t [MAX_WORD_BYTES-1:0] window_t;

  typedef struct packed {
    logic [2:0] cnt;
    byte_t [3:0] b;
  } norm_t;

  typedef struct packed {
    logic ban_go;
    logic unban_go;
    logic found_any;
  } cell_cmd_t;

  typedef struct packed {
    logic found;
    logic taken;
  } cell_chain_t;

  function automatic logic is_word(input logic [MODE_W-1:0] m);
    return (m == MODE_BAN) || (m == MODE_UNBAN);
  endfunction

  function automatic logic [2:0] seq_len(input byte_t c);
    if (c[7] == 1'b0) return 3'd1;
    if ((c & 8'hE0) == 8'hC0) return 3'd2;
    if ((c & 8'hF0) == 8'hE0) return 3'd3;
    if ((c & 8'hF8) == 8'hF0) return 3'd4;
    return 3'd0;
  endfunction

  // cyrillic homoglyph to latin: {hit, letter}
  function automatic logic [8:0] glyph(input logic [10:0] cp);
    case (cp)
      11'h425, 11'h445: return {1'b1, 8'h78};
      11'h41E, 11'h43E: return {1'b1, 8'h6F};
      11'h410, 11'h430: return {1'b1, 8'h61};
      11'h421, 11'h441: return {1'b1, 8'h73};
      11'h412, 11'h432: return {1'b1, 8'h76};
      11'h41D, 11'h43D: return {1'b1, 8'h6E};
      11'h420, 11'h440: return {1'b1, 8'h72};
      11'h415, 11'h435: return {1'b1, 8'h65};
      11'h418, 11'h438: return {1'b1, 8'h69};
      11'h423, 11'h443: return {1'b1, 8'h75};
      11'h411, 11'h431: return {1'b1, 8'h62};
      11'h413, 11'h433: return {1'b1, 8'h67};
      11'h414, 11'h434: return {1'b1, 8'h64};
      11'h417, 11'h437: return {1'b1, 8'h7A};
      11'h41A, 11'h43A: return {1'b1, 8'h6B};
      11'h41B, 11'h43B: return {1'b1, 8'h6C};
      11'h41C, 11'h43C: return {1'b1, 8'h6D};
      11'h41F, 11'h43F: return {1'b1, 8'h70};
      11'h422, 11'h442: return {1'b1, 8'h74};
      11'h424, 11'h444: return {1'b1, 8'h66};
      11'h406, 11'h456: return {1'b1, 8'h69};
      default: return 9'd0;
    endcase
  endfunction

  // normalize one complete sequence of n bytes
  function automatic norm_t norm_seq(input byte_t [3:0] s, input logic [2:0] n);
    norm_t r;
    logic [10:0] cp;
    logic [8:0] g;
    r = '0;
    cp = {s[0][4:0], s[1][5:0]};
    g = glyph(cp);
    case (n)
      3'd1: begin
        if (!(s[0] inside {8'h20, 8'h2E, 8'h2D, 8'h5F, 8'h2A})) begin
          r.cnt = 3'd1;
          r.b[0] = (s[0] inside {[8'h41:8'h5A]}) ? s[0] + 8'd32 : s[0];
        end
      end
      3'd2: begin
        if (g[8]) begin
          r.cnt = 3'd1;
          r.b[0] = g[7:0];
        end else if (cp[10:8] == 3'b100) begin
          r.cnt = 3'd2;
          r.b[0] = s[0];
          r.b[1] = s[1];
        end
      end
      3'd3, 3'd4: begin
        r.cnt = n;
        r.b = s;
      end
      default: r = '0;
    endcase
    return r;
  endfunction

  // bytes left behind a truncated lead, normalized again
  function automatic norm_t norm_tail(input byte_t [2:0] pend, input logic [1:0] have);
    norm_t r;
    norm_t a;
    logic [1:0] len;
    logic [2:0] n0;
    r = '0;
    len = (have == 2'd0) ? 2'd0 : have - 2'd1;
    n0 = seq_len(pend[1]);
    if (len == 2'd2 && n0 == 3'd2) begin
      r = norm_seq({16'h0, pend[2], pend[1]}, 3'd2);
    end else begin
      if (len != 2'd0 && n0 == 3'd1) r = norm_seq({24'h0, pend[1]}, 3'd1);
      if (len == 2'd2 && seq_len(pend[2]) == 3'd1) begin
        a = norm_seq({24'h0, pend[2]}, 3'd1);
        if (a.cnt != 3'd0) begin
          r.b[r.cnt[1:0]] = a.b[0];
          r.cnt = r.cnt + 3'd1;
        end
      end
    end
    return r;
  endfunction

endpackage

FILE: rtl/nmwf_if.sv
// nmwf_if: valid/ready channel interfaces for input bytes and run results
// depends on nmwf_pkg
interface nmwf_in_if;
  logic valid;
  logic ready;
  logic [nmwf_pkg::MODE_W-1:0] mode;
  logic [7:0] data_byte;
  logic last_byte;
  modport source(output valid, mode, data_byte, last_byte, input ready);
  modport sink(input valid, mode, data_byte, last_byte, output ready);
endinterface

interface nmwf_out_if;
  logic valid;
  logic ready;
  logic matched;
  logic [nmwf_pkg::STAT_W-1:0] status;
  logic [nmwf_pkg::WU_W-1:0] words_used;
  modport source(output valid, matched, status, words_used, input ready);
  modport sink(input valid, matched, status, words_used, output ready);
endinterface

FILE: rtl/nmwf_cell.sv
// nmwf_cell: one word slot, stored newest-byte-first, compared against the
// history window and the staged word; depends on nmwf_pkg
module nmwf_cell (
  input  logic                       clk,
  input  logic                       rst_n,
  input  nmwf_pkg::window_t          hist,
  input  logic [nmwf_pkg::LEN_W-1:0] hcnt,
  input  nmwf_pkg::window_t          stg,
  input  logic [nmwf_pkg::LEN_W-1:0] scnt,
  input  nmwf_pkg::cell_cmd_t        cmd,
  input  nmwf_pkg::cell_chain_t      chain_in,
  output nmwf_pkg::cell_chain_t      chain_out,
  output logic                       hit,
  output logic                       valid_o
);
  import nmwf_pkg::*;

  window_t word_r;
  logic [LEN_W-1:0] len_r;
  logic valid_r;
  logic h_all, s_all, eq_s;

  always_comb begin
    h_all = 1'b1;
    s_all = 1'b1;
    for (int j = 0; j < MAX_WORD_BYTES; j++) begin
      if (LEN_W'(j) < len_r) begin
        if (word_r[j] != hist[j]) h_all = 1'b0;
        if (word_r[j] != stg[j]) s_all = 1'b0;
      end
    end
  end

  assign eq_s = valid_r && (len_r == scnt) && s_all;
  assign hit = valid_r && (len_r != '0) && (len_r <= hcnt) && h_all;
  assign chain_out.found = chain_in.found | eq_s;
  assign chain_out.taken = chain_in.taken | !valid_r;
  assign valid_o = valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      len_r <= '0;
    end else if (cmd.ban_go && !cmd.found_any && !valid_r && !chain_in.taken) begin
      valid_r <= 1'b1;
      len_r <= scnt;
    end else if (cmd.unban_go && eq_s && !chain_in.found) begin
      valid_r <= 1'b0;
      len_r <= '0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.ban_go && !cmd.found_any && !valid_r && !chain_in.taken) word_r <= stg;
  end

endmodule

FILE: rtl/normalized_multi_word_filter.sv
// normalized_multi_word_filter: byte normalizer, history and staging shift lines,
// and a row of word cells; depends on nmwf_pkg, nmwf_if, nmwf_cell
// sequence: each accepted byte is taken in S_IDLE, then each normalized byte it yields (up to 4)
// is shifted out in S_EMIT; a final byte adds S_FLUSH (up to 2 tail bytes), S_ACT for the table
// action and S_DONE for the result; one byte at a time: the next is taken only after the emit
// buffer drains; a waiting result stalls the next run in S_DONE; reset: synchronous rst_n empties table and run
module normalized_multi_word_filter (
  input logic clk,
  input logic rst_n,
  nmwf_in_if.sink in_ch,
  nmwf_out_if.source out_ch
);
  import nmwf_pkg::*;

  typedef enum logic [2:0] {S_IDLE, S_EMIT, S_FLUSH, S_ACT, S_DONE} state_t;

  state_t state_r;
  byte_t [3:0] buf_r;
  logic [2:0] bcnt_r;
  logic [MODE_W-1:0] mode_r;
  logic last_r, tail_r;
  byte_t [2:0] pend_r;
  logic [1:0] have_r;
  logic [2:0] need_r;
  window_t hist_r, stg_r;
  logic [LEN_W-1:0] hcnt_r, scnt_r;
  logic sovf_r, match_r, chk_r;
  logic out_valid_r, matched_r;
  logic [STAT_W-1:0] status_r;
  logic [WU_W-1:0] words_r;
  logic res_matched_r;
  logic [STAT_W-1:0] res_status_r;

  norm_t nrm, tl;
  byte_t [3:0] seq;
  logic [2:0] n_in;
  logic accept, any_hit, wmode, out_fire;
  logic [NUM_WORDS-1:0] hits, valids;
  logic [WU_W-1:0] pop;
  cell_chain_t chain [NUM_WORDS+1];
  cell_cmd_t cmd;

  assign accept = in_ch.valid && in_ch.ready;
  assign in_ch.ready = (state_r == S_IDLE);
  assign wmode = is_word(mode_r);
  assign any_hit = |hits;
  assign out_fire = (state_r == S_DONE) && (!out_valid_r || out_ch.ready);

  always_comb begin
    n_in = seq_len(in_ch.data_byte);
    nrm = '0;
    for (int i = 0; i < 3; i++) seq[i] = (2'(i) < have_r) ? pend_r[i] : in_ch.data_byte;
    seq[3] = in_ch.data_byte;
    if (have_r == 2'd0) begin
      if (n_in == 3'd1) nrm = norm_seq({24'h0, in_ch.data_byte}, 3'd1);
    end else if ({1'b0, have_r} + 3'd1 >= need_r) begin
      nrm = norm_seq(seq, need_r);
    end
    tl = norm_tail(pend_r, have_r);
    pop = '0;
    for (int i = 0; i < NUM_WORDS; i++) pop = pop + WU_W'(valids[i]);
  end

  assign cmd.ban_go = (state_r == S_ACT) && (mode_r == MODE_BAN) && !sovf_r;
  assign cmd.unban_go = (state_r == S_ACT) && (mode_r == MODE_UNBAN) && !sovf_r;
  assign cmd.found_any = chain[NUM_WORDS].found;
  assign chain[0] = '0;

  for (genvar w = 0; w < NUM_WORDS; w++) begin : g_cell
    nmwf_cell u_cell (
      .clk(clk), .rst_n(rst_n), .hist(hist_r), .hcnt(hcnt_r), .stg(stg_r), .scnt(scnt_r),
      .cmd(cmd), .chain_in(chain[w]), .chain_out(chain[w+1]), .hit(hits[w]),
      .valid_o(valids[w])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      bcnt_r <= '0;
      last_r <= 1'b0;
      tail_r <= 1'b0;
      have_r <= '0;
      need_r <= '0;
      hcnt_r <= '0;
      scnt_r <= '0;
      sovf_r <= 1'b0;
      match_r <= 1'b0;
      chk_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_fire || (out_valid_r && !out_ch.ready);
      match_r <= (state_r == S_ACT) ? 1'b0 : (match_r || (chk_r && any_hit));
      chk_r <= (state_r == S_EMIT) && !wmode;
      case (state_r)
        S_IDLE: begin
          if (accept) begin
            mode_r <= in_ch.mode;
            last_r <= in_ch.last_byte;
            tail_r <= 1'b0;
            buf_r <= nrm.b;
            bcnt_r <= nrm.cnt;
            if (have_r == 2'd0) begin
              if (n_in > 3'd1) begin
                pend_r[0] <= in_ch.data_byte;
                have_r <= 2'd1;
                need_r <= n_in;
              end
            end else if ({1'b0, have_r} + 3'd1 >= need_r) begin
              have_r <= '0;
              need_r <= '0;
            end else begin
              pend_r[have_r] <= in_ch.data_byte;
              have_r <= have_r + 2'd1;
            end
            if (nrm.cnt != 3'd0) state_r <= S_EMIT;
            else if (in_ch.last_byte) state_r <= S_FLUSH;
          end
        end
        S_EMIT: begin
          if (wmode) begin
            if (scnt_r < LEN_W'(MAX_WORD_BYTES)) begin
              stg_r <= {stg_r[MAX_WORD_BYTES-2:0], buf_r[0]};
              scnt_r <= scnt_r + 1'b1;
            end else begin
              sovf_r <= 1'b1;
            end
          end else begin
            hist_r <= {hist_r[MAX_WORD_BYTES-2:0], buf_r[0]};
            if (hcnt_r < LEN_W'(MAX_WORD_BYTES)) hcnt_r <= hcnt_r + 1'b1;
          end
          buf_r <= {8'h00, buf_r[3:1]};
          bcnt_r <= bcnt_r - 3'd1;
          if (bcnt_r == 3'd1) begin
            if (!last_r) state_r <= S_IDLE;
            else if (!tail_r) state_r <= S_FLUSH;
            else state_r <= S_ACT;
          end
        end
        S_FLUSH: begin
          buf_r <= tl.b;
          bcnt_r <= tl.cnt;
          tail_r <= 1'b1;
          have_r <= '0;
          need_r <= '0;
          state_r <= (tl.cnt != 3'd0) ? S_EMIT : S_ACT;
        end
        S_ACT: begin
          res_matched_r <= !wmode && (match_r || (chk_r && any_hit));
          if (!wmode) res_status_r <= ST_OK;
          else if (sovf_r) res_status_r <= ST_LONG;
          else if (mode_r == MODE_BAN)
            res_status_r <= (cmd.found_any || chain[NUM_WORDS].taken) ? ST_OK : ST_FULL;
          else res_status_r <= cmd.found_any ? ST_OK : ST_ABSENT;
          scnt_r <= '0;
          sovf_r <= 1'b0;
          hcnt_r <= '0;
          state_r <= S_DONE;
        end
        S_DONE: begin
          if (out_fire) begin
            matched_r <= res_matched_r;
            status_r <= res_status_r;
            words_r <= pop;
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_ch.valid = out_valid_r;
  assign out_ch.matched = matched_r;
  assign out_ch.status = status_r;
  assign out_ch.words_used = words_r;

endmodule

FILE: rtl/nmwf_chk.sv
// nmwf_chk: port-level checks on the filter's result channel and pacing
// depends on nmwf_pkg; bound to normalized_multi_word_filter
module nmwf_chk (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_valid,
  input logic                          in_ready,
  input logic                          in_last_byte,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic                          out_matched,
  input logic [nmwf_pkg::STAT_W-1:0]   out_status,
  input logic [nmwf_pkg::WU_W-1:0]     out_words_used
);
  import nmwf_pkg::*;

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_status) && $stable(out_words_used))
    else $error("result dropped while stalled");

  a_words: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_words_used <= WU_W'(NUM_WORDS))
    else $error("words_used out of range");

  a_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != ST_OK |-> !out_matched)
    else $error("match reported on word run");

  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_last_byte |=> !in_ready)
    else $error("final item not given its action cycles");

  a_rst: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind normalized_multi_word_filter nmwf_chk u_nmwf_chk (
  .clk(clk), .rst_n(rst_n), .in_valid(in_ch.valid), .in_ready(in_ch.ready),
  .in_last_byte(in_ch.last_byte), .out_valid(out_ch.valid), .out_ready(out_ch.ready),
  .out_matched(out_ch.matched), .out_status(out_ch.status),
  .out_words_used(out_ch.words_used)
);
